>>> src/gbpe_pkg.sv
// ============================================================================
// gbpe_pkg: shared types for the glyph bitmap pixel expander
// Item layouts on both channels, the command codes and the layout of the
// classified entries held in the queue between front and back.
// ============================================================================
package gbpe_pkg;

  // Command codes carried in the cmd field of an input item.
  localparam logic CmdHeader = 1'b0;
  localparam logic CmdData   = 1'b1;

  // Number of classified items held between front and back.
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic        [7:0]  glyph_width;
    logic        [7:0]  glyph_height;
    logic        [15:0] ink_color;
    logic        [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic        [15:0] pixel_color;
    logic               last;
  } out_item_t;

  typedef enum logic {
    KindHeader,
    KindData
  } kind_e;

  // One classified item as it waits in the queue.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [15:0] ink_color;
    logic [7:0]  data_byte;
  } entry_t;

  // Head of the queue as the back sees it.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

>>> src/gbpe_front.sv
// ============================================================================
// gbpe_front: input acceptance, classification and item queue
// Accepts items, sorts them into header or data entries, masks the ink
// color and holds them in a short queue until the back takes them.
// ============================================================================
module gbpe_front #(
  parameter int unsigned COLOR_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gbpe_pkg::in_item_t  in_item_i,
  output gbpe_pkg::head_t     head_o,
  input  logic                pop_i
);
  import gbpe_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [31:0] MaskWide =
    (COLOR_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COLOR_BITS) - 32'd1);
  localparam logic [15:0] ColorMask = MaskWide[15:0];
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(QueueDepth);

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  entry_t          new_entry;
  logic            push;
  logic            pop;

  assign in_stall_o = (count_q == FullCount);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != '0);

  always_comb begin
    new_entry.kind         = (in_item_i.cmd == CmdHeader) ? KindHeader : KindData;
    new_entry.origin_x     = in_item_i.origin_x;
    new_entry.origin_y     = in_item_i.origin_y;
    new_entry.glyph_width  = in_item_i.glyph_width;
    new_entry.glyph_height = in_item_i.glyph_height;
    new_entry.ink_color    = in_item_i.ink_color & ColorMask;
    new_entry.data_byte    = in_item_i.data_byte;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

endmodule

>>> src/gbpe_back.sv
// ============================================================================
// gbpe_back: glyph state and bit walker
// Applies headers to the glyph state and walks each data byte one bit a cycle
// unless a stalled sink holds it, one registered pixel per set bit in area.
// ============================================================================
module gbpe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbpe_pkg::head_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gbpe_pkg::out_item_t out_item_o
);
  import gbpe_pkg::*;

  logic [15:0] base_x_q, base_x_d;
  logic [15:0] base_y_q, base_y_d;
  logic [7:0]  width_q, width_d;
  logic [15:0] color_q, color_d;
  logic [7:0]  col_q, col_d;
  logic [7:0]  row_q, row_d;
  // Glyph positions not yet consumed; zero once the glyph area is used up.
  logic [15:0] rem_q, rem_d;
  logic [2:0]  bit_q, bit_d;
  logic        out_valid_q;
  out_item_t   out_item_q;

  logic        is_data;
  logic        in_area;
  logic        cur_bit;
  logic        later_set;
  logic        emit;
  logic        out_ready;
  logic        step;
  out_item_t   pixel;

  assign is_data   = (head_i.entry.kind == KindData);
  assign in_area   = (rem_q != '0);
  assign cur_bit   = head_i.entry.data_byte[3'd7 - bit_q];
  assign emit      = head_i.valid && is_data && in_area && cur_bit;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign step      = head_i.valid && (!emit || out_ready);
  assign pop_o     = step && (!is_data || (bit_q == 3'd7));

  // A later bit of this byte still produces a pixel when it is set and
  // its position falls before the end of the glyph area.
  always_comb begin
    logic [3:0] pos;
    later_set = 1'b0;
    for (int k = 1; k < 8; k++) begin
      pos = {1'b0, bit_q} + 4'(k);
      if ((pos <= 4'd7) && (16'(k) < rem_q) &&
          head_i.entry.data_byte[3'(4'd7 - pos)]) begin
        later_set = 1'b1;
      end
    end
  end

  always_comb begin
    pixel.pixel_x     = base_x_q + {8'd0, col_q};
    pixel.pixel_y     = base_y_q + {8'd0, row_q};
    pixel.pixel_color = color_q;
    pixel.last        = !later_set;
  end

  always_comb begin
    base_x_d = base_x_q;
    base_y_d = base_y_q;
    width_d  = width_q;
    color_d  = color_q;
    col_d    = col_q;
    row_d    = row_q;
    rem_d    = rem_q;
    bit_d    = bit_q;
    if (step) begin
      if (!is_data) begin
        base_x_d = head_i.entry.origin_x;
        base_y_d = head_i.entry.origin_y;
        width_d  = head_i.entry.glyph_width;
        color_d  = head_i.entry.ink_color;
        col_d    = '0;
        row_d    = '0;
        rem_d    = 16'(head_i.entry.glyph_width) * 16'(head_i.entry.glyph_height);
        bit_d    = '0;
      end else begin
        bit_d = bit_q + 3'd1;
        if (in_area) begin
          rem_d = rem_q - 16'd1;
          if (({1'b0, col_q} + 9'd1) >= {1'b0, width_q}) begin
            col_d = '0;
            row_d = row_q + 8'd1;
          end else begin
            col_d = col_q + 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q    <= '0;
      base_y_q    <= '0;
      width_q     <= '0;
      color_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      rem_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_x_q <= base_x_d;
      base_y_q <= base_y_d;
      width_q  <= width_d;
      color_q  <= color_d;
      col_q    <= col_d;
      row_q    <= row_d;
      rem_q    <= rem_d;
      bit_q    <= bit_d;
      if (out_ready) begin
        out_valid_q <= emit && step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && step) begin
      out_item_q <= pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A data entry leaves the queue only after its eighth bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_data) |-> (bit_q == 3'd7))
    else $error("data entry popped before its last bit");

  // A header restarts the counters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !is_data) |=> (col_q == '0) && (row_q == '0) && (bit_q == '0))
    else $error("header did not restart the counters");

  // The column counter stays inside the glyph width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q != '0) |-> (col_q < width_q))
    else $error("column counter ran past the glyph width");

  // A pending pixel is never overwritten while the sink stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(emit && step))
    else $error("pixel overwritten while stalled");

endmodule

>>> src/glyph_bitmap_pixel_expander.sv
// ============================================================================
// glyph_bitmap_pixel_expander: 1 bit per pixel glyph blitter, MSB first
// Turns a glyph header and a stream of packed bitmap bytes into pixel
// writes at origin plus column and row, in the held ink color.
// ============================================================================
//
//   Channel | Direction | Handshake               | Item
//   --------+-----------+-------------------------+---------------------------
//   in      | sink      | in_valid_i / in_stall_o | header or bitmap data byte
//   out     | source    | out_valid_o/out_stall_i | one pixel write, last flag
//
// The back applies a header item at once and walks a data byte one glyph
// bit at a time, in the bit walker in gbpe_back.
// Results come from an output register: a byte accepted into an empty queue
// is written into the queue first, and its first pixel then into that register.
// Reset clears the glyph state to zero and empties the queue; data that
// arrives before any header draws nothing.
// A stalled sink holds the walker only on cycles that would write a pixel;
// the queue keeps accepting items until it is full.
//
module glyph_bitmap_pixel_expander #(
  // Significant bits of the ink color; higher bits are written as zero.
  parameter int unsigned COLOR_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gbpe_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gbpe_pkg::out_item_t out_item_o
);
  import gbpe_pkg::*;

  // Head of the item queue and the back's request to drop it.
  head_t head;
  logic  pop;

  // The front classifies each item and queues it, so new items keep
  // arriving while the back is still walking an earlier byte.
  gbpe_front #(
    .COLOR_BITS (COLOR_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // The back owns the glyph state and produces the pixel writes.
  gbpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> sim/glyph_bitmap_pixel_expander_tb.sv
// ============================================================================
// glyph_bitmap_pixel_expander_tb: self-checking bench for the glyph expander
// Drives glyph headers and packed bitmap bytes into the block, predicts every
// pixel write in the bench and compares each write field by field, under
// three idle profiles on the two channels.
// ============================================================================
module glyph_bitmap_pixel_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbpe_pkg::*;

  // The block is built with its full color width; the mask below follows it.
  localparam int unsigned ColorBits = 16;
  localparam logic [31:0] ColorMaskWide =
    (ColorBits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ColorBits) - 32'd1);
  localparam logic [15:0] ColorMask = ColorMaskWide[15:0];

  // The back end walks a data byte bit by bit. After the last pixel has
  // arrived, the queue can still hold bytes of clear bits, so the bench lets
  // more byte times pass than the queue holds bytes before it treats the block as idle.
  localparam int SettleCycles = 8 * (QueueDepth + 2) + 8;

  // Cycles in a row without any item accepted on either channel before the
  // run is declared hung. A correct run stays far below this even with the
  // receiver stalling most of the time.
  localparam int WatchdogLimit = 4000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Idle rates in percent, changed only between phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int error_count = 0;
  int pixels_checked = 0;
  int idle_cycles = 0;

  // Glyph state as the bench expects the block to hold it. Reset clears it
  // all to zero, and reset is applied only once, so the initial values stand.
  logic [7:0]  column_pos = '0;
  logic [7:0]  row_pos = '0;
  logic [15:0] base_x = '0;
  logic [15:0] base_y = '0;
  logic [7:0]  width_held = '0;
  logic [7:0]  height_held = '0;
  logic [15:0] color_held = '0;

  // Pixel writes predicted but not yet seen on the output, oldest first.
  out_item_t pending_pixels[$];

  // Set with a nonblocking assignment once the queue is empty after an edge,
  // so the stimulus process reads it without racing the monitor.
  logic drained = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glyph_bitmap_pixel_expander #(
    .COLOR_BITS (ColorBits)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // --------------------------------------------------------------------------
  // Prediction and checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Walks the eight bits of a data byte over the glyph area the same way the
  // block does and queues one pixel write for each set bit inside the area.
  // The write for the last set bit of the byte carries the last flag.
  task automatic predict_pixels(input in_item_t item);
    out_item_t held;
    bit        have_held;
    have_held = 1'b0;
    held = '0;
    if (item.cmd == CmdHeader) begin
      base_x      = item.origin_x;
      base_y      = item.origin_y;
      width_held  = item.glyph_width;
      height_held = item.glyph_height;
      color_held  = item.ink_color & ColorMask;
      column_pos  = '0;
      row_pos     = '0;
    end else begin
      for (int b = 7; b >= 0; b--) begin
        // An empty glyph, or one whose rows are used up, swallows the bits.
        if (width_held == 8'd0 || row_pos >= height_held) break;
        if (item.data_byte[b]) begin
          if (have_held) pending_pixels.push_back(held);
          held.pixel_x     = base_x + 16'(column_pos);
          held.pixel_y     = base_y + 16'(row_pos);
          held.pixel_color = color_held;
          held.last        = 1'b0;
          have_held        = 1'b1;
        end
        // Bits run on into the next row with no padding at the row end.
        if ({1'b0, column_pos} + 9'd1 >= {1'b0, width_held}) begin
          column_pos = '0;
          row_pos    = row_pos + 8'd1;
        end else begin
          column_pos = column_pos + 8'd1;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        pending_pixels.push_back(held);
      end
    end
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected pixel write x=%h y=%h color=%h last=%b",
                                got.pixel_x, got.pixel_y, got.pixel_color, got.last));
    end else begin
      want = pending_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x)
        report_mismatch($sformatf("pixel %0d: pixel_x got %h want %h",
                                  pixels_checked, got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        report_mismatch($sformatf("pixel %0d: pixel_y got %h want %h",
                                  pixels_checked, got.pixel_y, want.pixel_y));
      if (got.pixel_color !== want.pixel_color)
        report_mismatch($sformatf("pixel %0d: pixel_color got %h want %h",
                                  pixels_checked, got.pixel_color, want.pixel_color));
      if (got.last !== want.last)
        report_mismatch($sformatf("pixel %0d: last got %b want %b",
                                  pixels_checked, got.last, want.last));
    end
    pixels_checked++;
  endtask

  // Both channels are sampled at the rising edge, before any nonblocking
  // update of that edge lands, so every process sees the same handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_pixels(in_item);
      if (out_valid && !out_stall) check_pixel(out_item);
    end
    drained <= (pending_pixels.size() == 0);
  end

  // The receiver stalls at random, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Hang detection: cycles in a row with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("ERROR @%0t: no item moved for %0d cycles", $realtime, WatchdogLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Fields that the command does not use are filled with noise, so the block
  // is seen to ignore them.
  function automatic in_item_t make_header(input logic [15:0] x, input logic [15:0] y,
                                           input logic [7:0] w, input logic [7:0] h,
                                           input logic [15:0] color);
    in_item_t item;
    item.cmd          = CmdHeader;
    item.origin_x     = x;
    item.origin_y     = y;
    item.glyph_width  = w;
    item.glyph_height = h;
    item.ink_color    = color;
    item.data_byte    = 8'($urandom);
    return item;
  endfunction

  function automatic in_item_t make_data(input logic [7:0] bits);
    in_item_t item;
    item.cmd          = CmdData;
    item.origin_x     = 16'($urandom);
    item.origin_y     = 16'($urandom);
    item.glyph_width  = 8'($urandom);
    item.glyph_height = 8'($urandom);
    item.ink_color    = 16'($urandom);
    item.data_byte    = bits;
    return item;
  endfunction

  // Offers one item, after a random idle gap, and returns at the edge where
  // the block takes it. Valid stays high into the next call, so back-to-back
  // items need no second assignment in one step.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid and waits until every predicted pixel has come out, then
  // lets the given number of cycles pass. Must follow an accepting edge.
  task automatic wait_for_drain(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (!drained);
    repeat (settle) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Out of reset the held size is zero, so data bytes draw nothing.
  task automatic test_data_before_header();
    send_item(make_data(8'hFF));
    send_item(make_data(8'h5A));
  endtask

  // Bits run across row ends, and bits past the glyph area are dropped while
  // the counters stay parked at the end.
  task automatic test_row_continuation();
    send_item(make_header(16'h0000, 16'h0000, 8'd3, 8'd2, 16'hFFFF));
    send_item(make_data(8'hFF));
    send_item(make_data(8'hFF));
    send_item(make_header(16'd10, 16'd20, 8'd5, 8'd3, 16'h1234));
    send_item(make_data(8'hA5));
    send_item(make_data(8'h3C));
  endtask

  // Origins at the edges of the signed range, so column and row additions
  // wrap, with the largest sizes, clear bytes and both ink extremes.
  task automatic test_extreme_coordinates();
    send_item(make_header(16'h7FFF, 16'h8000, 8'd255, 8'd255, 16'h0000));
    send_item(make_data(8'h80));
    send_item(make_data(8'h01));
    send_item(make_data(8'h00));
    send_item(make_header(16'hFFFF, 16'hFFFF, 8'd1, 8'd255, 16'h8001));
    send_item(make_data(8'hFF));
    send_item(make_header(16'h8000, 16'h7FFF, 8'd255, 8'd1, 16'hFFFF));
    send_item(make_data(8'hFF));
  endtask

  // Zero width or zero height makes the glyph empty.
  task automatic test_empty_glyphs();
    send_item(make_header(16'h0040, 16'h0040, 8'd0, 8'd7, 16'hFFFF));
    send_item(make_data(8'hFF));
    send_item(make_header(16'h0040, 16'h0040, 8'd9, 8'd0, 16'hFFFF));
    send_item(make_data(8'hFF));
  endtask

  // A header in the middle of a glyph restarts the counters at once.
  task automatic test_header_restart();
    send_item(make_header(16'd100, 16'hFF9C, 8'd8, 8'd8, 16'h0F0F));
    send_item(make_data(8'h55));
    send_item(make_header(16'hFFFE, 16'd3, 8'd4, 8'd4, 16'hF0F0));
    send_item(make_data(8'hC3));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------

  // Mostly well-formed glyphs: a header followed by just enough bytes to fill
  // it, with random content. Some glyphs overrun, some are cut short by the
  // next header, a few are empty or huge, and a few items are pure noise.
  // With hold_midway set, the sender stops halfway until the block has
  // delivered every pending pixel.
  task automatic test_random_traffic(input int items, input bit hold_midway);
    int          sent;
    int          pick;
    int          w;
    int          h;
    int          nbytes;
    bit          held_once;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  bits;
    sent = 0;
    held_once = 1'b0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(make_data(8'($urandom)));
        if ($urandom_range(1) == 0)
          send_item(make_header(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                                16'($urandom)));
        sent += 2;
      end else begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          w = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 255);
          h = (w == 0) ? $urandom_range(255) : 0;
        end else if (pick < 12) begin
          w = 255;
          h = $urandom_range(1, 255);
        end else if (pick < 16) begin
          w = $urandom_range(1, 3);
          h = 255;
        end else begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 12);
        end
        nbytes = (w * h + 7) / 8;
        if (w == 0 || h == 0) nbytes = $urandom_range(1, 3);
        else if (nbytes > 64) nbytes = $urandom_range(1, 12);
        else if ($urandom_range(9) == 0) nbytes += $urandom_range(1, 3);
        else if ($urandom_range(9) == 0) nbytes = $urandom_range(nbytes);
        // Origins near the wrap points half the time.
        x = ($urandom_range(1) == 0) ? 16'h7FF0 + 16'($urandom_range(31)) : 16'($urandom);
        y = ($urandom_range(1) == 0) ? 16'hFFF0 + 16'($urandom_range(31)) : 16'($urandom);
        send_item(make_header(x, y, 8'(w), 8'(h), 16'($urandom)));
        sent++;
        for (int i = 0; i < nbytes; i++) begin
          pick = $urandom_range(7);
          bits = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
          send_item(make_data(bits));
          sent++;
        end
      end
      if (hold_midway && !held_once && sent >= items / 2) begin
        wait_for_drain(0);
        held_once = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver stalls heavily.
    send_idle_pct  = 35;
    recv_stall_pct = 81;
    test_data_before_header();
    test_row_continuation();
    test_extreme_coordinates();
    test_empty_glyphs();
    test_header_restart();
    test_random_traffic(146, 1'b1);
    wait_for_drain(SettleCycles);

    // Phase two: the other way round, so the queue runs dry often.
    send_idle_pct  = 81;
    recv_stall_pct = 35;
    test_random_traffic(146, 1'b0);
    wait_for_drain(SettleCycles);

    // Phase three: both sides at full rate.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(146, 1'b0);
    wait_for_drain(SettleCycles);

    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d predicted pixel writes never arrived",
                                pending_pixels.size()));
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
src/gbpe_pkg.sv
src/gbpe_front.sv
src/gbpe_back.sv
src/glyph_bitmap_pixel_expander.sv
sim/glyph_bitmap_pixel_expander_tb.sv
